FILE: rtl/core/ssfp_pkg.sv
package ssfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  // Frame index: zero while no frame is open, otherwise slot + FRAME_START
  localparam logic [2:0] IDX_CLOSED  = 3'd0;
  localparam logic [2:0] FRAME_START = 3'd2;
  localparam logic [2:0] FRAME_LAST  = 3'd7;
  // Slots of the six-byte frame body: the two that feed the position register, and the first one
  localparam logic [2:0] SLOT_POS_HI = 3'd3;
  localparam logic [2:0] SLOT_POS_LO = 3'd4;
  localparam logic [2:0] SLOT_FIRST  = 3'd0;

  typedef struct packed {
    logic       valid;
    logic       overrun;
    logic [7:0] rx_byte;
  } ssfp_beat_t;

endpackage

FILE: rtl/core/servo_status_frame_parser.sv
// Servo status frame parser.
// Input channel: one received serial byte per beat (in_rx_byte) with its
// overrun flag (in_overrun); a beat is taken when in_valid is high and
// in_stall is low. An overrun byte leaves the parser state untouched.
// Result channel: exactly one result beat per input beat, in order:
// out_position (current position register), out_position_updated (this
// byte closed a frame with a good checksum) and out_checksum_error (this
// byte closed a frame with a bad checksum).
// Pipeline: an input beat passes through the input register, then the
// decode stage writes the result register.
// Throughput: one byte per cycle while the result side does not stall;
// the decode logic is a single 8-bit add and two 8-bit compares per byte.
// Stall: a result held by out_stall blocks the decode stage; the input
// register still takes one more byte if it is empty, after which in_stall rises.
// Reset (rst_n low, synchronous): no frame open, no half-header pending,
// position zero, both pipeline stages empty.
module servo_status_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_overrun,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_position,
  output logic        out_position_updated,
  output logic        out_checksum_error
);
  import ssfp_pkg::*;

  ssfp_beat_t beat;
  logic       advance;

  // Register the incoming byte
  ssfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_overrun (in_overrun),
    .in_stall   (in_stall),
    .advance    (advance),
    .beat       (beat)
  );

  // Advance the frame state and load the result register
  ssfp_decode u_dec (
    .clk                  (clk),
    .rst_n                (rst_n),
    .beat                 (beat),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_position         (out_position),
    .out_position_updated (out_position_updated),
    .out_checksum_error   (out_checksum_error)
  );

endmodule

FILE: rtl/core/ssfp_in_stage.sv
module ssfp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_overrun,
  output logic                in_stall,
  input  logic                advance,
  output ssfp_pkg::ssfp_beat_t beat
);
  import ssfp_pkg::*;

  logic       valid_r, valid_nxt;
  logic       overrun_r;
  logic [7:0] byte_r;
  logic       load;

  // Hold the beat while the decode stage cannot take it
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= in_rx_byte;
      overrun_r <= in_overrun;
    end
  end

  assign beat = '{valid: valid_r, overrun: overrun_r, rx_byte: byte_r};

endmodule

FILE: rtl/core/ssfp_decode.sv
module ssfp_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssfp_pkg::ssfp_beat_t beat,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_position,
  output logic                 out_position_updated,
  output logic                 out_checksum_error
);
  import ssfp_pkg::*;

  logic        half_r,   half_nxt;
  logic [2:0]  idx_r,    idx_nxt;
  logic [7:0]  sum_r,    sum_nxt;
  logic [7:0]  hi_r,     hi_nxt;
  logic [7:0]  lo_r,     lo_nxt;
  logic [15:0] pos_r,    pos_nxt;
  logic        vld_r,    vld_nxt;
  logic        upd_r,    upd_nxt;
  logic        err_r,    err_nxt;
  logic        take;
  logic [2:0]  slot;
  logic        is_hdr;

  assign take    = !vld_r || !out_stall;
  assign advance = beat.valid && take;
  assign vld_nxt = advance || (vld_r && out_stall);
  assign slot    = idx_r - FRAME_START;
  assign is_hdr  = (beat.rx_byte == HDR_BYTE);

  always_comb begin
    half_nxt = half_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    pos_nxt  = pos_r;
    upd_nxt  = 1'b0;
    err_nxt  = 1'b0;
    if (advance && !beat.overrun) begin
      if (is_hdr && !half_r) begin
        half_nxt = 1'b1;
      end else if (is_hdr) begin
        half_nxt = 1'b0;
        idx_nxt  = FRAME_START;
      end else if (idx_r != IDX_CLOSED) begin
        // Keep a running checksum over body bytes one to five
        sum_nxt = (slot == SLOT_FIRST) ? beat.rx_byte : sum_r + beat.rx_byte;
        if (slot == SLOT_POS_HI) begin
          hi_nxt = beat.rx_byte;
        end
        if (slot == SLOT_POS_LO) begin
          lo_nxt = beat.rx_byte;
        end
        if (idx_r == FRAME_LAST) begin
          sum_nxt = sum_r;
          idx_nxt = IDX_CLOSED;
          if (~sum_r == beat.rx_byte) begin
            pos_nxt = {hi_r, lo_r};
            upd_nxt = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      idx_r  <= IDX_CLOSED;
      pos_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      half_r <= half_nxt;
      idx_r  <= idx_nxt;
      pos_r  <= pos_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    if (advance) begin
      upd_r <= upd_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_valid            = vld_r;
  assign out_position         = pos_r;
  assign out_position_updated = upd_r;
  assign out_checksum_error   = err_r;

endmodule

FILE: rtl/core/ssfp_checker.sv
module ssfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        in_overrun,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_position,
  input logic        out_position_updated,
  input logic        out_checksum_error
);

  // A frame closes either good or bad, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_position_updated && out_checksum_error))
    else $error("both frame flags set");

  // Input backpressure only arises from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // Position moves only on a good-checksum beat
  a_pos_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (out_position != $past(out_position)))
      |-> (out_valid && out_position_updated))
    else $error("position changed without update");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_position)))
    else $error("stalled result changed");

endmodule

bind servo_status_frame_parser ssfp_checker u_ssfp_checker (.*);
